FILE: hdl/rgb2nv12_pkg.sv
// ----------------------------------------------------------------------------
// rgb2nv12_pkg
// Shared sizes, register indexes and payload widths of the RGB to NV12
// (BT.601, 4:2:0) converter.
// ----------------------------------------------------------------------------
package rgb2nv12_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned LineDepth  = (MaxWidth + 1) / 2;
  localparam int unsigned LineIdxW   = $clog2(LineDepth);
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned CfgW       = 13;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned PixW       = 8;
  localparam int unsigned PairW      = PixW + 1;
  localparam int unsigned LineW      = 3 * PairW;

  localparam logic [CfgIdxW-1:0] CFG_RECT_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECT_HEIGHT = 1'd1;

  localparam logic [CfgW-1:0] RECT_WIDTH_RST  = 13'd16;
  localparam logic [CfgW-1:0] RECT_HEIGHT_RST = 13'd16;

endpackage

FILE: hdl/rgb2nv12_pix_if.sv
// ----------------------------------------------------------------------------
// rgb2nv12_pix_if
// Pixel channel: one BGR pixel per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgb2nv12_pix_if
  import rgb2nv12_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] blue;
  logic [PixW-1:0] green;
  logic [PixW-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

FILE: hdl/rgb2nv12_res_if.sv
// ----------------------------------------------------------------------------
// rgb2nv12_res_if
// Result channel: luma per pixel, chroma per completed 2x2 block.
// ----------------------------------------------------------------------------
interface rgb2nv12_res_if
  import rgb2nv12_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] luma;
  logic            chroma_valid;
  logic [PixW-1:0] cb;
  logic [PixW-1:0] cr;
  logic            frame_last;

  modport source (output valid, output luma, output chroma_valid, output cb, output cr,
                  output frame_last, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb, input cr,
                  input frame_last, output ready);
endinterface

FILE: hdl/rgb_to_nv12_bt601_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_nv12_bt601_converter
// BT.601 limited range RGB to YCbCr 4:2:0 for a raster-order rectangle.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  pix_i    in   blue, green, red
//  res_o    out  luma, chroma_valid, cb, cr, frame_last
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (rect_width, rect_height)
//
//  One pixel per clock sustained while res_o is ready; each pixel passes stage 1 and then the output stage.
//  Line store read is issued at accept, its registered data meets the pixel
//  in stage 1; chroma and luma are registered into the output stage.
//  Stalls on res_o hold both stages; pix_i.ready drops only when both are full.
//  rst_ni clears counters, valids and stage registers and sets the rectangle to 16x16; the line store needs no clear.
// ----------------------------------------------------------------------------
module rgb_to_nv12_bt601_converter
  import rgb2nv12_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  rgb2nv12_pix_if.sink       pix_i,
  rgb2nv12_res_if.source     res_o
);

  typedef struct packed {
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  blue;
    logic [PairW-1:0] pr;
    logic [PairW-1:0] pg;
    logic [PairW-1:0] pb;
    logic             emit;
    logic             use_line;
    logic             frame_last;
  } stage_t;

  logic [CfgW-1:0]     width_q, height_q;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;
  logic [3*PixW-1:0]   left_q;
  logic                s1_valid_q, out_valid_q;
  stage_t              s1_q;
  logic [LineW-1:0]    line_rd_q;
  logic [LineW-1:0]    line_mem [LineDepth];

  logic [CfgW-1:0]     w_eff, h_eff, w_m1, h_m1;
  logic                in_accept, advance;
  logic                last_col, last_row, col_odd, row_odd, pair_done;
  logic [LineIdxW-1:0] line_idx;
  logic                line_we;
  stage_t              s1_d;
  logic [PixW-1:0]     lb, lg, lr;

  logic [PairW:0]      sb, sg, sr;
  logic [PixW-1:0]     ab, ag, ar;
  logic [15:0]         luma_sum, cb_sum, cr_sum;

  assign advance     = !out_valid_q || res_o.ready;
  assign pix_i.ready = !s1_valid_q || advance;
  assign in_accept   = pix_i.valid && pix_i.ready;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = CfgW'(1);
    else if (width_q > CfgW'(MaxWidth)) w_eff = CfgW'(MaxWidth);
    h_eff = height_q;
    if (height_q == '0) h_eff = CfgW'(1);
    else if (height_q > CfgW'(MaxHeight)) h_eff = CfgW'(MaxHeight);
    w_m1 = w_eff - CfgW'(1);
    h_m1 = h_eff - CfgW'(1);
  end

  assign col_odd   = col_q[0];
  assign row_odd   = row_q[0];
  assign last_col  = CfgW'(col_q) >= w_m1;
  assign last_row  = CfgW'(row_q) >= h_m1;
  assign pair_done = col_odd || last_col;
  assign line_idx  = col_q[ColW-1:1];

  assign {lr, lg, lb} = left_q;

  always_comb begin
    s1_d.red   = pix_i.red;
    s1_d.green = pix_i.green;
    s1_d.blue  = pix_i.blue;
    if (col_odd) begin
      s1_d.pb = PairW'(lb) + PairW'(pix_i.blue);
      s1_d.pg = PairW'(lg) + PairW'(pix_i.green);
      s1_d.pr = PairW'(lr) + PairW'(pix_i.red);
    end else begin
      s1_d.pb = {pix_i.blue, 1'b0};
      s1_d.pg = {pix_i.green, 1'b0};
      s1_d.pr = {pix_i.red, 1'b0};
    end
    s1_d.emit       = pair_done && (row_odd || last_row);
    s1_d.use_line   = row_odd;
    s1_d.frame_last = last_col && last_row;
  end

  assign line_we = in_accept && pair_done && !row_odd && !last_row;

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_idx] <= {s1_d.pr, s1_d.pg, s1_d.pb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_rd_q <= line_mem[line_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RECT_WIDTH_RST;
      height_q <= RECT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RECT_WIDTH:  width_q  <= cfg_data_i;
        CFG_RECT_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_accept) begin
      if (!col_odd) left_q <= {pix_i.red, pix_i.green, pix_i.blue};
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_q       <= '0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      s1_q       <= s1_d;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // 2x2 block sum, then floor average
  always_comb begin
    if (s1_q.use_line) begin
      sb = (PairW+1)'(line_rd_q[PairW-1:0])         + (PairW+1)'(s1_q.pb);
      sg = (PairW+1)'(line_rd_q[2*PairW-1:PairW])   + (PairW+1)'(s1_q.pg);
      sr = (PairW+1)'(line_rd_q[3*PairW-1:2*PairW]) + (PairW+1)'(s1_q.pr);
    end else begin
      sb = {s1_q.pb, 1'b0};
      sg = {s1_q.pg, 1'b0};
      sr = {s1_q.pr, 1'b0};
    end
    ab = sb[PairW:2];
    ag = sg[PairW:2];
    ar = sr[PairW:2];

    luma_sum = 16'd66 * 16'(s1_q.red) + 16'd129 * 16'(s1_q.green)
             + 16'd25 * 16'(s1_q.blue) + 16'd128;
    // offset 128 << 8 keeps both sums positive; results stay in 16..240
    cb_sum = 16'd112 * 16'(ab) + 16'd32896 - 16'd38 * 16'(ar) - 16'd74 * 16'(ag);
    cr_sum = 16'd112 * 16'(ar) + 16'd32896 - 16'd94 * 16'(ag) - 16'd18 * 16'(ab);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q        <= 1'b0;
      res_o.luma         <= '0;
      res_o.chroma_valid <= 1'b0;
      res_o.cb           <= '0;
      res_o.cr           <= '0;
      res_o.frame_last   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        res_o.luma         <= luma_sum[15:8] + PixW'(16);
        res_o.chroma_valid <= s1_q.emit;
        res_o.cb           <= s1_q.emit ? cb_sum[15:8] : '0;
        res_o.cr           <= s1_q.emit ? cr_sum[15:8] : '0;
        res_o.frame_last   <= s1_q.frame_last;
      end
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
